FILE: hdl/shs_pkg.sv
package shs_pkg;

   localparam int NUM_SERVERS_DEF  = 16;
   localparam int PENDING_BITS_DEF = 16;

   localparam logic [3:0] OP_RD_START = 4'd0;
   localparam logic [3:0] OP_RD_END   = 4'd1;
   localparam logic [3:0] OP_WR_START = 4'd2;
   localparam logic [3:0] OP_WR_END   = 4'd3;
   localparam logic [3:0] OP_SAMPLE   = 4'd4;
   localparam logic [3:0] OP_WORKING  = 4'd5;
   localparam logic [3:0] OP_DEFECT   = 4'd6;
   localparam logic [3:0] OP_QUERY    = 4'd7;
   localparam logic [3:0] OP_TICK     = 4'd8;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_RTT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_RTT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INFLUENCE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTHING = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT   = 3'd4;

   localparam logic [15:0] REF_RTT_RST   = 16'd100;
   localparam logic [16:0] INFLUENCE_RST = 17'd32768;
   localparam logic [8:0]  SMOOTHING_RST = 9'd8;
   localparam logic [31:0] TIMEOUT_RST   = 32'd2000;

   localparam logic [9:0]  DEFECT_CEILING = 10'd1000;
   localparam logic [17:0] SCORE_ONE      = 18'd65536;
   localparam logic [17:0] SCORE_MAX      = 18'd131072;

   localparam int DVD_W = 50;
   localparam int DVS_W = 33;

   typedef struct packed {
      logic capture;
      logic clear_wr;
      logic update;
      logic fold_go;
      logic fold_take;
      logic write;
      logic score_go;
      logic score_take;
      logic pen_chk;
      logic pen_go;
      logic pen_take;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic need_fold;
      logic rtt_known;
      logic pen;
      logic div_done;
      logic out_free;
   } sts_type;

endpackage

FILE: hdl/shs_ram.sv
module shs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/shs_div.sv
module shs_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [shs_pkg::DVD_W-1:0]  dividend,
   input  logic [shs_pkg::DVS_W-1:0]  divisor,
   output logic                       done,
   output logic [shs_pkg::DVD_W-1:0]  quotient
);
   import shs_pkg::*;

   localparam int CNT_W = $clog2(DVD_W);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   sh;
   logic [DVS_W:0]   diff;
   logic             ge;

   always_comb begin
      sh      = {rem_ff, quo_ff[DVD_W-1]};
      diff    = sh - {1'b0, dvs_ff};
      ge      = (sh >= {1'b0, dvs_ff});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: hdl/shs_ctrl.sv
module shs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  shs_pkg::sts_type sts,
   output shs_pkg::cmd_type cmd
);
   import shs_pkg::*;

   localparam logic [3:0] S_CLEAR      = 4'd0;
   localparam logic [3:0] S_IDLE       = 4'd1;
   localparam logic [3:0] S_READ       = 4'd2;
   localparam logic [3:0] S_FOLD_GO    = 4'd3;
   localparam logic [3:0] S_FOLD_WAIT  = 4'd4;
   localparam logic [3:0] S_WRITE      = 4'd5;
   localparam logic [3:0] S_SCORE_GO   = 4'd6;
   localparam logic [3:0] S_SCORE_WAIT = 4'd7;
   localparam logic [3:0] S_PEN_CHK    = 4'd8;
   localparam logic [3:0] S_PEN_GO     = 4'd9;
   localparam logic [3:0] S_PEN_WAIT   = 4'd10;
   localparam logic [3:0] S_OUT        = 4'd11;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_READ;
            end
         end
         S_READ: begin
            cmd.update = 1'b1;
            state_in   = sts.need_fold ? S_FOLD_GO : S_WRITE;
         end
         S_FOLD_GO: begin
            cmd.fold_go = 1'b1;
            state_in    = S_FOLD_WAIT;
         end
         S_FOLD_WAIT: begin
            if (sts.div_done) begin
               cmd.fold_take = 1'b1;
               state_in      = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.write = 1'b1;
            state_in  = sts.rtt_known ? S_SCORE_GO : S_PEN_CHK;
         end
         S_SCORE_GO: begin
            cmd.score_go = 1'b1;
            state_in     = S_SCORE_WAIT;
         end
         S_SCORE_WAIT: begin
            if (sts.div_done) begin
               cmd.score_take = 1'b1;
               state_in       = S_PEN_CHK;
            end
         end
         S_PEN_CHK: begin
            cmd.pen_chk = 1'b1;
            state_in    = sts.pen ? S_PEN_GO : S_OUT;
         end
         S_PEN_GO: begin
            cmd.pen_go = 1'b1;
            state_in   = S_PEN_WAIT;
         end
         S_PEN_WAIT: begin
            if (sts.div_done) begin
               cmd.pen_take = 1'b1;
               state_in     = S_OUT;
            end
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

FILE: hdl/shs_dp.sv
module shs_dp #(
   parameter int NUM_SERVERS  = shs_pkg::NUM_SERVERS_DEF,
   parameter int PENDING_BITS = shs_pkg::PENDING_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [3:0]                        req_op,
   input  logic [3:0]                        req_server,
   input  logic [31:0]                       req_rtt_sample,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [shs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                       csr_wdata,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [15:0]                       rsp_pending_reads,
   output logic [15:0]                       rsp_pending_writes,
   output logic [9:0]                        rsp_defect_count,
   output logic [31:0]                       rsp_rtt_average,
   output logic                              rsp_rtt_known,
   output logic                              rsp_penalized,
   output logic [17:0]                       rsp_score,
   output logic                              rsp_status,
   input  shs_pkg::cmd_type                  cmd,
   output shs_pkg::sts_type                  sts
);
   import shs_pkg::*;

   localparam int IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
   localparam int PB    = PENDING_BITS;
   localparam int ENT_W = 2 * PB + 10 + 32 + 1 + 32;

   // configuration
   logic        use_rtt_ff;
   logic [15:0] ref_ff;
   logic [16:0] infl_ff;
   logic [8:0]  sf_ff;
   logic [31:0] tmo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_rtt_ff <= 1'b0;
         ref_ff     <= REF_RTT_RST;
         infl_ff    <= INFLUENCE_RST;
         sf_ff      <= SMOOTHING_RST;
         tmo_ff     <= TIMEOUT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_USE_RTT:   use_rtt_ff <= csr_wdata[0];
            CSR_REF_RTT:   ref_ff     <= csr_wdata[15:0];
            CSR_INFLUENCE: infl_ff    <= csr_wdata[16:0];
            CSR_SMOOTHING: sf_ff      <= csr_wdata[8:0];
            CSR_TIMEOUT:   tmo_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // server index folding into the table
   logic [IDX_W-1:0] mod_tab [16];
   for (genvar v = 0; v < 16; v++) begin : g_mod
      assign mod_tab[v] = IDX_W'(v % NUM_SERVERS);
   end

   // table
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [ENT_W-1:0] ram_wdata;
   logic [ENT_W-1:0] ram_rdata;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [IDX_W-1:0] idx_ff;
   logic [3:0]       op_ff;
   logic [31:0]      smp_ff;

   shs_ram #(.WIDTH(ENT_W), .DEPTH(NUM_SERVERS), .AW(IDX_W)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (cmd.capture),
      .raddr (mod_tab[req_server]),
      .rdata (ram_rdata)
   );

   logic [PB-1:0] rd_reads, rd_writes;
   logic [9:0]    rd_def;
   logic [31:0]   rd_avg;
   logic          rd_valid;
   logic [31:0]   rd_stamp;

   assign {rd_reads, rd_writes, rd_def, rd_avg, rd_valid, rd_stamp} = ram_rdata;

   // working entry
   logic [PB-1:0] reads_ff, reads_in, writes_ff, writes_in;
   logic [9:0]    def_ff, def_in;
   logic [31:0]   avg_ff, avg_in;
   logic          valid_ff, valid_in;
   logic [31:0]   stamp_ff, stamp_in;
   logic [31:0]   now_ff, now_in;
   logic          st_ff, st_in;
   logic [41:0]   fold_ff, fold_in;
   logic [40:0]   fold_prod;
   logic [8:0]    sf_eff, fm1;
   logic [31:0]   smp_cl;
   logic [PB-1:0] pmax;

   logic [DVD_W-1:0] div_dvd;
   logic [DVS_W-1:0] div_dvs;
   logic             div_done;
   logic [DVD_W-1:0] div_quo;

   logic [49:0]   prod_ff;
   logic [32:0]   sum_ff;
   logic          neg_ff;
   logic [32:0]   mag;
   logic [17:0]   f_ff, f_in;
   logic          pen_ff;
   logic          pen_c;
   logic [19:0]   fv;
   logic [19:0]   qs;
   logic [31:0]   age;

   always_comb begin
      pmax      = {PB{1'b1}};
      sf_eff    = (sf_ff == 9'd0) ? 9'd1 : sf_ff;
      fm1       = sf_eff - 9'd1;
      smp_cl    = (smp_ff == 32'd0) ? 32'd1 : smp_ff;
      fold_prod = {9'b0, rd_avg} * {32'b0, fm1};
      fold_in   = {1'b0, fold_prod} + {10'b0, smp_cl};
      reads_in  = rd_reads;
      writes_in = rd_writes;
      def_in    = rd_def;
      avg_in    = rd_avg;
      valid_in  = rd_valid;
      stamp_in  = rd_stamp;
      now_in    = now_ff;
      st_in     = 1'b0;
      unique case (op_ff)
         OP_RD_START: begin
            if (rd_reads == pmax) st_in = 1'b1;
            else                  reads_in = rd_reads + 1'b1;
         end
         OP_RD_END: begin
            if (rd_reads == '0) st_in = 1'b1;
            else                reads_in = rd_reads - 1'b1;
         end
         OP_WR_START: begin
            if (rd_writes == pmax) st_in = 1'b1;
            else                   writes_in = rd_writes + 1'b1;
         end
         OP_WR_END: begin
            if (rd_writes == '0) st_in = 1'b1;
            else                 writes_in = rd_writes - 1'b1;
         end
         OP_SAMPLE: begin
            if (use_rtt_ff && !rd_valid) begin
               avg_in   = smp_cl;
               valid_in = 1'b1;
            end
         end
         OP_WORKING: def_in = '0;
         OP_DEFECT: begin
            if (rd_def < DEFECT_CEILING) def_in = rd_def + 10'd1;
            stamp_in = now_ff;
         end
         OP_TICK: now_in = now_ff + 32'd1;
         default: ;
      endcase
   end

   assign sts.need_fold = (op_ff == OP_SAMPLE) && use_rtt_ff && rd_valid;

   always_comb begin
      mag = ({1'b0, avg_ff} > {17'b0, ref_ff}) ? ({1'b0, avg_ff} - {17'b0, ref_ff})
                                              : ({17'b0, ref_ff} - {1'b0, avg_ff});
      age   = now_ff - stamp_ff;
      pen_c = (def_ff != 10'd0) && (age < tmo_ff);
      qs    = {2'b0, div_quo[17:0]};
      fv    = neg_ff ? ({2'b0, SCORE_ONE} - qs) : ({2'b0, SCORE_ONE} + qs);
      f_in  = f_ff;
      if (cmd.write) begin
         f_in = SCORE_ONE;
      end else if (cmd.score_take) begin
         if (fv[19])                        f_in = '0;
         else if (fv > {2'b0, SCORE_MAX})   f_in = SCORE_MAX;
         else                               f_in = fv[17:0];
      end else if (cmd.pen_take) begin
         f_in = div_quo[17:0];
      end
   end

   always_comb begin
      div_dvd = {32'b0, f_ff};
      div_dvs = {22'b0, 11'({1'b0, def_ff} + 11'd1)};
      if (cmd.fold_go) begin
         div_dvd = {8'b0, fold_ff};
         div_dvs = {24'b0, sf_eff};
      end else if (cmd.score_go) begin
         div_dvd = prod_ff;
         div_dvs = sum_ff;
      end
   end

   shs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.fold_go | cmd.score_go | cmd.pen_go),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign clr_in    = clr_ff + 1'b1;
   assign ram_we    = cmd.clear_wr | cmd.write;
   assign ram_waddr = cmd.clear_wr ? clr_ff : idx_ff;
   assign ram_wdata = cmd.clear_wr ? '0
                    : {reads_ff, writes_ff, def_ff, avg_ff, valid_ff, stamp_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         now_ff <= '0;
      end else begin
         if (cmd.clear_wr) clr_ff <= clr_in;
         if (cmd.update)   now_ff <= now_in;
      end
      if (cmd.capture) begin
         op_ff  <= req_op;
         idx_ff <= mod_tab[req_server];
         smp_ff <= req_rtt_sample;
      end
      if (cmd.update) begin
         reads_ff  <= reads_in;
         writes_ff <= writes_in;
         def_ff    <= def_in;
         avg_ff    <= avg_in;
         valid_ff  <= valid_in;
         stamp_ff  <= stamp_in;
         st_ff     <= st_in;
         fold_ff   <= fold_in;
      end
      if (cmd.fold_take) begin
         avg_ff <= (div_quo == '0) ? 32'd1 : div_quo[31:0];
      end
      if (cmd.write) begin
         prod_ff <= {33'b0, infl_ff} * {17'b0, mag};
         sum_ff  <= {17'b0, ref_ff} + {1'b0, avg_ff};
         neg_ff  <= ({1'b0, avg_ff} > {17'b0, ref_ff});
      end
      if (cmd.pen_chk) begin
         pen_ff <= pen_c;
      end
      f_ff <= f_in;
   end

   assign sts.clear_last = (clr_ff == IDX_W'(NUM_SERVERS - 1));
   assign sts.rtt_known  = valid_ff;
   assign sts.pen        = pen_c;
   assign sts.div_done   = div_done;

   // result register
   logic        rv_ff;
   logic [15:0] o_reads_ff, o_writes_ff;
   logic [9:0]  o_def_ff;
   logic [31:0] o_avg_ff;
   logic        o_known_ff, o_pen_ff, o_st_ff;
   logic [17:0] o_score_ff;

   assign sts.out_free = !rv_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rv_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rv_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         o_reads_ff  <= 16'(reads_ff);
         o_writes_ff <= 16'(writes_ff);
         o_def_ff    <= def_ff;
         o_avg_ff    <= avg_ff;
         o_known_ff  <= valid_ff;
         o_pen_ff    <= pen_ff;
         o_score_ff  <= f_ff;
         o_st_ff     <= st_ff;
      end
   end

   assign rsp_valid          = rv_ff;
   assign rsp_pending_reads  = o_reads_ff;
   assign rsp_pending_writes = o_writes_ff;
   assign rsp_defect_count   = o_def_ff;
   assign rsp_rtt_average    = o_avg_ff;
   assign rsp_rtt_known      = o_known_ff;
   assign rsp_penalized      = o_pen_ff;
   assign rsp_score          = o_score_ff;
   assign rsp_status         = o_st_ff;

endmodule

FILE: hdl/server_health_scoreboard_top.sv
// Per-server health scoreboard: each event updates one table entry and returns one result
// with the entry's counts, smoothed round-trip time, penalty flag and a Q2.16 score. After
// reset the table is swept to zero, one entry per cycle, before the first event is taken;
// configuration writes are taken at any time. An event that needs no division passes
// through the read, write, penalty check and output states; the round-trip fold, the
// latency score and the defect penalty each add, when needed, a division on the 50-step
// shared restoring divider. A finished result waits in the output register while the
// next event is taken.
module server_health_scoreboard_top #(
   parameter int NUM_SERVERS  = shs_pkg::NUM_SERVERS_DEF,
   parameter int PENDING_BITS = shs_pkg::PENDING_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [3:0]                    req_op,
   input  logic [3:0]                    req_server,
   input  logic [31:0]                   req_rtt_sample,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [shs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wdata,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [15:0]                   rsp_pending_reads,
   output logic [15:0]                   rsp_pending_writes,
   output logic [9:0]                    rsp_defect_count,
   output logic [31:0]                   rsp_rtt_average,
   output logic                          rsp_rtt_known,
   output logic                          rsp_penalized,
   output logic [17:0]                   rsp_score,
   output logic                          rsp_status
);
   import shs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   shs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   shs_dp #(.NUM_SERVERS(NUM_SERVERS), .PENDING_BITS(PENDING_BITS)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_op             (req_op),
      .req_server         (req_server),
      .req_rtt_sample     (req_rtt_sample),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pending_reads  (rsp_pending_reads),
      .rsp_pending_writes (rsp_pending_writes),
      .rsp_defect_count   (rsp_defect_count),
      .rsp_rtt_average    (rsp_rtt_average),
      .rsp_rtt_known      (rsp_rtt_known),
      .rsp_penalized      (rsp_penalized),
      .rsp_score          (rsp_score),
      .rsp_status         (rsp_status),
      .cmd                (cmd),
      .sts                (sts)
   );

endmodule

FILE: tb/sv/shs_checker.sv
`timescale 1ns / 1ps

module shs_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [3:0]                    req_op,
   input  logic [3:0]                    req_server,
   input  logic [31:0]                   req_rtt_sample,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [shs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wdata,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [15:0]                   rsp_pending_reads,
   input  logic [15:0]                   rsp_pending_writes,
   input  logic [9:0]                    rsp_defect_count,
   input  logic [31:0]                   rsp_rtt_average,
   input  logic                          rsp_rtt_known,
   input  logic                          rsp_penalized,
   input  logic [17:0]                   rsp_score,
   input  logic                          rsp_status,
   output int                            failures,
   output int                            outstanding
);
   import shs_pkg::*;

   typedef struct packed {
      logic [15:0] reads;
      logic [15:0] writes;
      logic [9:0]  defects;
      logic [31:0] rtt_avg;
      logic        rtt_known;
      logic        penalized;
      logic [17:0] score;
      logic        status;
   } health_type;

   // shadow registers and table
   logic        use_rtt;
   logic [15:0] ref_rtt;
   logic [16:0] influence;
   logic [8:0]  smoothing;
   logic [31:0] timeout_ms;

   logic [15:0] reads_tab   [16];
   logic [15:0] writes_tab  [16];
   logic [9:0]  defects_tab [16];
   logic [31:0] avg_tab     [16];
   logic        known_tab   [16];
   logic [31:0] stamp_tab   [16];
   logic [31:0] now_ms;

   health_type expected_health[$];

   assign outstanding = expected_health.size();

   task automatic health_update(input logic [3:0] op, input logic [3:0] srv,
                                input logic [31:0] smp, output health_type r);
      logic        sat;
      logic [63:0] fac;
      logic [63:0] acc;
      logic [31:0] since;
      longint      f;
      longint      refv;
      longint      rttv;
      sat = 1'b0;
      case (op)
         OP_RD_START: if (reads_tab[srv] == 16'hFFFF) sat = 1'b1;
                      else reads_tab[srv] = reads_tab[srv] + 1'b1;
         OP_RD_END:   if (reads_tab[srv] == 16'd0) sat = 1'b1;
                      else reads_tab[srv] = reads_tab[srv] - 1'b1;
         OP_WR_START: if (writes_tab[srv] == 16'hFFFF) sat = 1'b1;
                      else writes_tab[srv] = writes_tab[srv] + 1'b1;
         OP_WR_END:   if (writes_tab[srv] == 16'd0) sat = 1'b1;
                      else writes_tab[srv] = writes_tab[srv] - 1'b1;
         OP_SAMPLE: begin
            if (use_rtt) begin
               if (smp == 32'd0) smp = 32'd1;
               if (!known_tab[srv]) begin
                  avg_tab[srv]   = smp;
                  known_tab[srv] = 1'b1;
               end else begin
                  fac = (smoothing == 9'd0) ? 64'd1 : 64'(smoothing);
                  acc = (64'(avg_tab[srv]) * (fac - 64'd1) + 64'(smp)) / fac;
                  if (acc == 64'd0) acc = 64'd1;
                  avg_tab[srv] = acc[31:0];
               end
            end
         end
         OP_WORKING: defects_tab[srv] = 10'd0;
         OP_DEFECT: begin
            if (defects_tab[srv] < DEFECT_CEILING) defects_tab[srv] = defects_tab[srv] + 1'b1;
            stamp_tab[srv] = now_ms;
         end
         OP_TICK: now_ms = now_ms + 1'b1;
         default: ;
      endcase
      since = now_ms - stamp_tab[srv];
      r.penalized = (defects_tab[srv] != 10'd0) && (since < timeout_ms);
      f = 65536;
      if (known_tab[srv]) begin
         refv = longint'(ref_rtt);
         rttv = longint'(avg_tab[srv]);
         f = f + (longint'(influence) * (refv - rttv)) / (refv + rttv);
      end
      if (f < 0) f = 0;
      if (f > 131072) f = 131072;
      if (r.penalized) f = f / (longint'(defects_tab[srv]) + 1);
      r.reads     = reads_tab[srv];
      r.writes    = writes_tab[srv];
      r.defects   = defects_tab[srv];
      r.rtt_avg   = avg_tab[srv];
      r.rtt_known = known_tab[srv];
      r.score     = f[17:0];
      r.status    = sat;
   endtask

   task automatic compare_field(input string name, input longint exp_v, input longint act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      health_type e;
      health_type r;
      if (reset) begin
         use_rtt    = 1'b0;
         ref_rtt    = REF_RTT_RST;
         influence  = INFLUENCE_RST;
         smoothing  = SMOOTHING_RST;
         timeout_ms = TIMEOUT_RST;
         now_ms     = '0;
         for (int i = 0; i < 16; i++) begin
            reads_tab[i]   = '0;
            writes_tab[i]  = '0;
            defects_tab[i] = '0;
            avg_tab[i]     = '0;
            known_tab[i]   = '0;
            stamp_tab[i]   = '0;
         end
         expected_health.delete();
         failures = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_USE_RTT:   use_rtt    = csr_wdata[0];
               CSR_REF_RTT:   ref_rtt    = csr_wdata[15:0];
               CSR_INFLUENCE: influence  = csr_wdata[16:0];
               CSR_SMOOTHING: smoothing  = csr_wdata[8:0];
               CSR_TIMEOUT:   timeout_ms = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_health.size() == 0) begin
               $error("result transfer with no expectation waiting");
               failures++;
            end else begin
               e = expected_health.pop_front();
               compare_field("pending_reads", e.reads, rsp_pending_reads);
               compare_field("pending_writes", e.writes, rsp_pending_writes);
               compare_field("defect_count", e.defects, rsp_defect_count);
               compare_field("rtt_average", e.rtt_avg, rsp_rtt_average);
               compare_field("rtt_known", e.rtt_known, rsp_rtt_known);
               compare_field("penalized", e.penalized, rsp_penalized);
               compare_field("score", e.score, rsp_score);
               compare_field("status", e.status, rsp_status);
            end
         end
         if (req_valid && !req_stall) begin
            health_update(req_op, req_server, req_rtt_sample, r);
            expected_health.push_back(r);
         end
      end
   end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import shs_pkg::*;

   localparam int IDLE_LIMIT = 5000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [3:0]           req_op = '0;
   logic [3:0]           req_server = '0;
   logic [31:0]          req_rtt_sample = '0;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_wdata = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [15:0]          rsp_pending_reads;
   logic [15:0]          rsp_pending_writes;
   logic [9:0]           rsp_defect_count;
   logic [31:0]          rsp_rtt_average;
   logic                 rsp_rtt_known;
   logic                 rsp_penalized;
   logic [17:0]          rsp_score;
   logic                 rsp_status;

   int failures;
   int outstanding;
   int burst_left = 0;
   int events_sent = 0;
   int results_seen = 0;
   int idle_cycles = 0;
   int stall_mode = 0;
   int stall_pct = 0;
   int stall_timer = 0;

   always #5 clock = ~clock;

   server_health_scoreboard_top u_dut (.*);

   shs_checker u_checker (.*);

   // receiver stall pattern: free-running, light, heavy or long runs
   always @(posedge clock) begin
      if (stall_timer == 0) begin
         stall_mode  <= $urandom_range(0, 3);
         stall_pct   <= $urandom_range(10, 90);
         stall_timer <= $urandom_range(50, 400);
      end else begin
         stall_timer <= stall_timer - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         3: rsp_stall <= (stall_timer % 40) < 25;
         default: rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      endcase
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) results_seen++;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_event(input logic [3:0] op, input logic [3:0] srv,
                             input logic [31:0] smp, input bit no_gaps = 0);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         if (!no_gaps && $urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_server     <= srv;
      req_rtt_sample <= smp;
      do @(posedge clock); while (req_stall);
      burst_left--;
      events_sent++;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      burst_left = 0;
      while (outstanding != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_config(input logic use_r, input logic [15:0] ref_ms,
                             input logic [16:0] infl, input logic [8:0] smooth,
                             input logic [31:0] tmo);
      csr_write(CSR_USE_RTT, {31'd0, use_r});
      csr_write(CSR_REF_RTT, {16'd0, ref_ms});
      csr_write(CSR_INFLUENCE, {15'd0, infl});
      csr_write(CSR_SMOOTHING, {23'd0, smooth});
      csr_write(CSR_TIMEOUT, tmo);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 3);
         2: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
         3: return $urandom_range(0, 70000);
         default: return $urandom_range(1, 400);
      endcase
   endfunction

   function automatic logic [3:0] pick_op();
      int w;
      w = $urandom_range(0, 99);
      if (w < 36) return 4'($urandom_range(0, 3));
      if (w < 56) return OP_SAMPLE;
      if (w < 61) return OP_WORKING;
      if (w < 71) return OP_DEFECT;
      if (w < 76) return OP_QUERY;
      if (w < 95) return OP_TICK;
      return 4'($urandom_range(9, 15));
   endfunction

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: underflow, sample extremes, defect handling, odd op codes
      set_config(1'b1, 16'd100, 17'd65536, 9'd8, 32'd5);
      send_event(OP_QUERY, 4'd0, 32'd0);
      send_event(OP_RD_END, 4'd0, 32'd0);
      send_event(OP_WR_END, 4'd15, 32'd0);
      send_event(OP_RD_START, 4'd15, 32'hFFFF_FFFF);
      send_event(OP_WR_START, 4'd15, 32'd0);
      send_event(OP_SAMPLE, 4'd1, 32'd0);
      send_event(OP_SAMPLE, 4'd1, 32'hFFFF_FFFF);
      send_event(OP_SAMPLE, 4'd2, 32'hFFFF_FFFF);
      send_event(OP_SAMPLE, 4'd2, 32'd0);
      send_event(OP_SAMPLE, 4'd3, 32'd100);
      send_event(OP_DEFECT, 4'd3, 32'd0);
      send_event(OP_DEFECT, 4'd3, 32'd0);
      send_event(OP_TICK, 4'd3, 32'd0);
      send_event(OP_QUERY, 4'd3, 32'd0);
      send_event(OP_WORKING, 4'd3, 32'd0);
      send_event(4'd9, 4'd3, 32'hA5A5_5A5A);
      send_event(4'd15, 4'd3, 32'h5A5A_A5A5);
      repeat (5) send_event(OP_TICK, 4'd7, 32'd0);
      drain();

      // defect ceiling on one entry
      for (int i = 0; i < 1002; i++) send_event(OP_DEFECT, 4'd10, 32'd0, 1);
      send_event(OP_WORKING, 4'd10, 32'd0);
      drain();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: set_config(1'b1, 16'd100, 17'd32768, 9'd8, 32'd2000);
            1: set_config(1'b1, 16'd1, 17'h1FFFF, 9'd0, 32'd0);
            2: set_config(1'b1, 16'hFFFF, 17'd0, 9'd1, 32'hFFFF_FFFF);
            3: set_config(1'b0, 16'd250, 17'd65536, 9'd256, 32'd20);
            4: set_config(1'b1, 16'd300, 17'd131071, 9'h1FF, 32'd7);
            default: set_config(1'b1, 16'($urandom_range(1, 65535)),
                                17'($urandom_range(0, 131071)),
                                9'($urandom_range(0, 511)), $urandom);
         endcase
         for (int i = 0; i < 150; i++) begin
            send_event(pick_op(), 4'($urandom), pick_sample());
            if ($urandom_range(0, 199) == 0) drain();
         end
         drain();
      end

      $display("Covered %0d events with %0d results checked over 7 register settings,",
               events_sent, results_seen);
      $display("including counter underflow, the defect ceiling, score clamping and idle samples.");
      if (failures == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
